### src/prqs_pkg.sv
// Package for the priority ready-queue scheduler: sizes, operation and status
// codes, and the structure passed from the queue picker to the top level.
// No dependencies.
package prqs_pkg;

    localparam int THREAD_SLOTS    = 8;
    localparam int PRIORITY_LEVELS = 16;

    localparam int TID_W    = $clog2(THREAD_SLOTS);
    localparam int PRIO_W   = $clog2(PRIORITY_LEVELS);
    localparam int FUNC_W   = 2;
    localparam int NP_W     = 5;
    localparam int STATUS_W = 2;

    localparam int IN_FIELDS_W  = FUNC_W + TID_W + NP_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + TID_W + PRIO_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef logic [TID_W-1:0]  tid_t;
    typedef logic [PRIO_W-1:0] prio_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REMOVE   = 2'd0,
        FUNC_INSERT   = 2'd1,
        FUNC_SET_PRIO = 2'd2,
        FUNC_SELECT   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_ALREADY    = 2'd1,
        ST_NOT_HEAD   = 2'd2,
        ST_NONE_READY = 2'd3
    } status_t;

    typedef struct packed {
        logic  found;
        prio_t level;
    } pick_t;

endpackage

### src/prqs_pick.sv
// Queue picker: finds the lowest-numbered non-empty ready queue.
// Depends on prqs_pkg.
module prqs_pick
    import prqs_pkg::*;
(
    input  logic [PRIORITY_LEVELS-1:0] nonempty,
    output pick_t                      pick
);

    always_comb
    begin
        pick.found = |nonempty;
        pick.level = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                pick.level = PRIO_W'(i);
            end
        end
    end

endmodule

### src/priority_ready_queue_scheduler.sv
// Top level of the priority ready-queue scheduler: input register, queue state,
// operation logic and result register. Depends on prqs_pkg and prqs_pick.
//
// Usage:
//   Slave stream s_axis carries one operation per item: remove a thread from
//   the head of its priority queue, insert a thread, set a priority and
//   insert, or select the head of the lowest-numbered non-empty queue.
//   Master stream m_axis returns exactly one result item per operation, in
//   order: status, selected thread and priority.
//   The accepting edge loads the input register; the first later edge at
//   which m_axis is not stalled updates the queue links and loads the result
//   register shown on m_axis. Throughput is one item per cycle while m_axis
//   does not stall; all queue state is small register arrays read and written
//   in the same cycle.
//   When m_axis stalls, the result register holds, the input register holds
//   the next item, and s_axis_tready drops once both are full.
//   Reset empties every queue, marks all threads not ready at priority zero
//   and discards any item in flight.
module priority_ready_queue_scheduler
    import prqs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] func, [4:2] thread_id, [9:5] new_priority, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [4:2] selected_thread, [8:5] old_priority, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                   in_valid_reg;
    func_t                  in_func_reg;
    tid_t                   in_tid_reg;
    logic signed [NP_W-1:0] in_np_reg;

    logic    m_valid_reg;
    status_t out_status_reg;
    tid_t    out_sel_reg;
    prio_t   out_prio_reg;

    tid_t  link_next_reg [THREAD_SLOTS];
    tid_t  link_next_next [THREAD_SLOTS];
    logic  [THREAD_SLOTS-1:0] link_valid_reg, link_valid_next;
    prio_t slot_prio_reg [THREAD_SLOTS];
    prio_t slot_prio_next [THREAD_SLOTS];
    logic  [THREAD_SLOTS-1:0] slot_ready_reg, slot_ready_next;
    tid_t  head_reg [PRIORITY_LEVELS];
    tid_t  head_next [PRIORITY_LEVELS];
    tid_t  tail_reg [PRIORITY_LEVELS];
    tid_t  tail_next [PRIORITY_LEVELS];
    logic  [PRIORITY_LEVELS-1:0] nonempty_reg, nonempty_next;

    pick_t   pick;
    logic    advance;
    logic    fire;
    status_t status_c;
    tid_t    sel_c;
    prio_t   oldp_c;
    logic    ins_c;
    prio_t   ins_prio_c;
    prio_t   cur_prio;
    logic [NP_W-2:0] np_mag;

    prqs_pick u_pick (
        .nonempty (nonempty_reg),
        .pick     (pick)
    );

    assign advance       = !m_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_prio_reg, out_sel_reg, out_status_reg};

    assign cur_prio = slot_prio_reg[in_tid_reg];
    assign np_mag   = in_np_reg[NP_W-2:0];

    always_comb
    begin
        link_next_next  = link_next_reg;
        link_valid_next = link_valid_reg;
        slot_prio_next  = slot_prio_reg;
        slot_ready_next = slot_ready_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        nonempty_next   = nonempty_reg;
        status_c        = ST_DONE;
        sel_c           = '0;
        oldp_c          = '0;
        ins_c           = 1'b0;
        ins_prio_c      = cur_prio;

        case (in_func_reg)
            FUNC_SELECT:
            begin
                if (pick.found)
                begin
                    sel_c  = head_reg[pick.level];
                    oldp_c = pick.level;
                end
                else
                begin
                    status_c = ST_NONE_READY;
                end
            end
            FUNC_REMOVE:
            begin
                oldp_c = cur_prio;
                if (!slot_ready_reg[in_tid_reg])
                begin
                    status_c = ST_ALREADY;
                end
                else if (!nonempty_reg[cur_prio] || head_reg[cur_prio] != in_tid_reg)
                begin
                    status_c = ST_NOT_HEAD;
                end
                else
                begin
                    if (link_valid_reg[in_tid_reg])
                    begin
                        head_next[cur_prio] = link_next_reg[in_tid_reg];
                    end
                    else
                    begin
                        nonempty_next[cur_prio] = 1'b0;
                        head_next[cur_prio]     = '0;
                        tail_next[cur_prio]     = '0;
                    end
                    slot_ready_next[in_tid_reg] = 1'b0;
                    link_valid_next[in_tid_reg] = 1'b0;
                    link_next_next[in_tid_reg]  = '0;
                end
            end
            FUNC_INSERT:
            begin
                oldp_c = cur_prio;
                ins_c  = 1'b1;
            end
            FUNC_SET_PRIO:
            begin
                oldp_c = cur_prio;
                if (slot_ready_reg[in_tid_reg])
                begin
                    status_c = ST_ALREADY;
                end
                else
                begin
                    if (!in_np_reg[NP_W-1])
                    begin
                        if (int'(np_mag) >= PRIORITY_LEVELS)
                        begin
                            ins_prio_c = PRIO_W'(PRIORITY_LEVELS - 1);
                        end
                        else
                        begin
                            ins_prio_c = PRIO_W'(np_mag);
                        end
                    end
                    slot_prio_next[in_tid_reg] = ins_prio_c;
                    ins_c = 1'b1;
                end
            end
            default:
            begin
                status_c = ST_DONE;
            end
        endcase

        if (ins_c)
        begin
            if (slot_ready_reg[in_tid_reg])
            begin
                status_c = ST_ALREADY;
            end
            else
            begin
                if (nonempty_reg[ins_prio_c])
                begin
                    link_next_next[tail_reg[ins_prio_c]]  = in_tid_reg;
                    link_valid_next[tail_reg[ins_prio_c]] = 1'b1;
                end
                else
                begin
                    head_next[ins_prio_c]     = in_tid_reg;
                    nonempty_next[ins_prio_c] = 1'b1;
                end
                tail_next[ins_prio_c]       = in_tid_reg;
                link_valid_next[in_tid_reg] = 1'b0;
                link_next_next[in_tid_reg]  = '0;
                slot_ready_next[in_tid_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            link_valid_reg <= '0;
            slot_ready_reg <= '0;
            nonempty_reg   <= '0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                link_next_reg[i] <= '0;
                slot_prio_reg[i] <= '0;
            end
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                m_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                link_next_reg  <= link_next_next;
                link_valid_reg <= link_valid_next;
                slot_prio_reg  <= slot_prio_next;
                slot_ready_reg <= slot_ready_next;
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                nonempty_reg   <= nonempty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_func_reg <= func_t'(s_axis_tdata[FUNC_W-1:0]);
            in_tid_reg  <= s_axis_tdata[FUNC_W +: TID_W];
            in_np_reg   <= s_axis_tdata[FUNC_W + TID_W +: NP_W];
        end
        if (fire)
        begin
            out_status_reg <= status_c;
            out_sel_reg    <= sel_c;
            out_prio_reg   <= oldp_c;
        end
    end

endmodule

### src/prqs_checker.sv
// Port-level checks for the priority ready-queue scheduler, bound to the top
// level. Depends on prqs_pkg and priority_ready_queue_scheduler.
module prqs_checker
    import prqs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    a_no_sel_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_W-1:0] != ST_DONE
        |-> m_axis_tdata[STATUS_W +: TID_W] == '0)
        else $error("thread reported with failing status");

    a_none_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_W-1:0] == ST_NONE_READY
        |-> m_axis_tdata[STATUS_W + TID_W +: PRIO_W] == '0)
        else $error("priority reported with nothing ready");

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (.*);
